>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on every clock edge outside reset.
`define TAH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define TAH_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define TAH_ASSERT(lbl, clk, rst_n, prop, msg)
`define TAH_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/tah_pkg.sv
// Types and constants of the temperature alarm block.
package tah_pkg;

    localparam int TEMP_BITS     = 16;
    localparam int MV_BITS       = 12;
    localparam int MV_FULL_SCALE = 3300;
    localparam int MV_OFFSET     = 500;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic signed [TEMP_BITS-1:0] t_temp;

    typedef enum logic [1:0] {
        LIGHT_GREEN  = 2'd0,
        LIGHT_YELLOW = 2'd1,
        LIGHT_RED    = 2'd2
    } t_light;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCALE_BY_TEN   = 3'd0,
        CFG_LOW_CRIT_ENTER = 3'd1,
        CFG_LOW_CRIT_EXIT  = 3'd2,
        CFG_WARN_ENTER     = 3'd3,
        CFG_WARN_EXIT      = 3'd4,
        CFG_HIGH_CRIT_ENTER = 3'd5,
        CFG_HIGH_CRIT_EXIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic  scale_by_ten;
        t_temp low_crit_enter;
        t_temp low_crit_exit;
        t_temp warn_enter;
        t_temp warn_exit;
        t_temp high_crit_enter;
        t_temp high_crit_exit;
    } t_cfg;

    localparam t_temp RST_LOW_CRIT_ENTER  = 16'sd50;
    localparam t_temp RST_LOW_CRIT_EXIT   = 16'sd70;
    localparam t_temp RST_WARN_ENTER      = 16'sd850;
    localparam t_temp RST_WARN_EXIT       = 16'sd830;
    localparam t_temp RST_HIGH_CRIT_ENTER = 16'sd1050;
    localparam t_temp RST_HIGH_CRIT_EXIT  = 16'sd1030;

endpackage

>>> rtl/tah_cfg_regs.sv
// Configuration register file: scale select and six thresholds.
module tah_cfg_regs
    import tah_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE_BY_TEN:    n_cfg.scale_by_ten    = i_cfg_data[0];
                CFG_LOW_CRIT_ENTER:  n_cfg.low_crit_enter  = t_temp'(i_cfg_data);
                CFG_LOW_CRIT_EXIT:   n_cfg.low_crit_exit   = t_temp'(i_cfg_data);
                CFG_WARN_ENTER:      n_cfg.warn_enter      = t_temp'(i_cfg_data);
                CFG_WARN_EXIT:       n_cfg.warn_exit       = t_temp'(i_cfg_data);
                CFG_HIGH_CRIT_ENTER: n_cfg.high_crit_enter = t_temp'(i_cfg_data);
                CFG_HIGH_CRIT_EXIT:  n_cfg.high_crit_exit  = t_temp'(i_cfg_data);
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_by_ten    <= 1'b1;
            r_cfg.low_crit_enter  <= RST_LOW_CRIT_ENTER;
            r_cfg.low_crit_exit   <= RST_LOW_CRIT_EXIT;
            r_cfg.warn_enter      <= RST_WARN_ENTER;
            r_cfg.warn_exit       <= RST_WARN_EXIT;
            r_cfg.high_crit_enter <= RST_HIGH_CRIT_ENTER;
            r_cfg.high_crit_exit  <= RST_HIGH_CRIT_EXIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/tah_convert.sv
// Sample to temperature conversion: millivolts, offset, optional times ten.
module tah_convert
    import tah_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0] i_raw,
    input  logic                   i_scale_by_ten,
    output t_temp                  o_temp
);

    localparam int ProdW = SAMPLE_BITS + MV_BITS;

    logic [ProdW-1:0]   prod;
    logic [MV_BITS-1:0] mv;
    t_temp              off;

    always_comb begin
        prod = ProdW'(i_raw) * ProdW'(MV_FULL_SCALE);
        // divide by full scale of the converter: keep the top bits
        mv   = prod[ProdW-1 -: MV_BITS];
        off  = $signed({{(TEMP_BITS - MV_BITS){1'b0}}, mv}) - t_temp'(MV_OFFSET);
        // times ten as 8x + 2x
        o_temp = i_scale_by_ten ? t_temp'((off <<< 3) + (off <<< 1)) : off;
    end

endmodule

>>> rtl/tah_light_fsm.sv
// Green/yellow/red hysteresis state machine with first-sample pick.
module tah_light_fsm
    import tah_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  t_temp  i_temp,
    input  t_cfg   i_cfg,
    output t_light o_light
);

    t_light r_light;
    t_light n_light;
    t_light cur;
    logic   r_seen;
    logic   crit;

    // before the first sample the machine acts as if green
    assign cur  = r_seen ? r_light : LIGHT_GREEN;
    assign crit = (i_temp < i_cfg.low_crit_enter) || (i_temp >= i_cfg.high_crit_enter);

    always_comb begin
        unique case (cur)
            LIGHT_GREEN: begin
                if (crit)                          n_light = LIGHT_RED;
                else if (i_temp >= i_cfg.warn_enter) n_light = LIGHT_YELLOW;
                else                               n_light = LIGHT_GREEN;
            end
            LIGHT_YELLOW: begin
                if (crit)                          n_light = LIGHT_RED;
                else if (i_temp < i_cfg.warn_exit) n_light = LIGHT_GREEN;
                else                               n_light = LIGHT_YELLOW;
            end
            LIGHT_RED: begin
                if (i_temp >= i_cfg.low_crit_exit && i_temp < i_cfg.warn_enter)
                    n_light = LIGHT_GREEN;
                else if (i_temp >= i_cfg.warn_enter && i_temp < i_cfg.high_crit_exit)
                    n_light = LIGHT_YELLOW;
                else
                    n_light = LIGHT_RED;
            end
            default: n_light = LIGHT_RED;
        endcase
    end

    always_comb begin
        o_light = r_light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= LIGHT_GREEN;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_light <= n_light;
            r_seen  <= 1'b1;
        end
    end

endmodule

>>> rtl/temperature_alarm_hysteresis_top.sv
// Top level of the three-level temperature alarm with hysteresis.
//
// Usage:
//   Input channel: drive i_raw_sample with i_in_valid; a beat is taken at a
//   clock edge with i_in_valid high and o_in_stall low.
//   Output channel: each input beat yields one beat of o_light_state
//   (0 green, 1 yellow, 2 red) and o_temp_tenths, taken at an edge
//   with o_out_valid high and i_out_stall low.
//   Config: write register i_cfg_index with i_cfg_data when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high. Write only while idle.
// Pipeline and throughput:
//   Two register stages (sample, result): a taken beat goes on to the result
//   register; one beat per cycle is sustained while i_out_stall stays low.
//   The constant multiply by 3300, the six threshold compares and the light
//   update all sit between the sample register and the result register.
// Reset: synchronous, active low. Clears both stages, loads the default
//   thresholds, sets the light to green and arms the first-sample pick.
// Stall: while i_out_stall holds, the result holds; the sample stage keeps
//   filling, and o_in_stall rises only when both stages are full.
`include "assert_macros.svh"

module temperature_alarm_hysteresis_top
    import tah_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_BITS-1:0]   i_raw_sample,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_light_state,
    output logic signed [TEMP_BITS-1:0] o_temp_tenths,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg   cfg;
    t_temp  conv_temp;
    t_light light;

    // stage 1: captured sample
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_raw;
    // stage 2: result register
    logic                   r_out_valid;
    t_temp                  r_out_temp;

    logic out_free;
    logic s1_free;
    logic in_accept;
    logic out_load;

    // A stage may take a new beat when empty or when its beat moves on.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_free   = !r_s1_valid || out_free;
    assign in_accept = i_in_valid && s1_free;
    assign out_load  = r_s1_valid && out_free;

    assign o_in_stall = !s1_free;

    tah_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tah_convert #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_convert (
        .i_raw          (r_s1_raw),
        .i_scale_by_ten (cfg.scale_by_ten),
        .o_temp         (conv_temp)
    );

    // The light register advances together with the result register, so
    // it always holds the light of the beat on the outputs.
    tah_light_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (out_load),
        .i_temp  (conv_temp),
        .i_cfg   (cfg),
        .o_light (light)
    );

    // valid bits: advance when the downstream stage frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload: load on a move, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_raw <= i_raw_sample;
        end
        if (out_load) begin
            r_out_temp <= conv_temp;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_light_state = light;
    assign o_temp_tenths = r_out_temp;

    // Input backpressure only when both stages hold a beat.
    `TAH_ASSERT(a_stall_full, i_clk, i_rst_n,
        o_in_stall |-> (r_s1_valid && r_out_valid),
        "input stalled with a free pipeline stage")

    // A new result only appears from a loaded sample stage.
    `TAH_ASSERT(a_out_from_s1, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_s1_valid),
        "result valid rose without a beat in the sample stage")

    // The light moves only when a beat enters the result register.
    `TAH_ASSERT(a_light_on_load, i_clk, i_rst_n,
        ($past(i_rst_n) && (o_light_state != $past(o_light_state))) |-> $past(out_load),
        "light changed without a result load")

    // Nothing enters the result register while it is held by a stall.
    `TAH_NEVER(a_no_overwrite, i_clk, i_rst_n,
        out_load && r_out_valid && i_out_stall,
        "result register overwritten while held")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the temperature alarm: directed table, then random threshold phases.
module tb;
    import tah_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int RAW_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int ITEM_TARGET  = 1850;
    localparam int DRAIN_CYCLES = 4;      // result stage is registered after the sample stage
    localparam int GAP_PERCENT  = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    // Temperature span in tenths with and without the ten-times scaling.
    localparam int TENTHS_MIN    = -5000;
    localparam int TENTHS_MAX    = 27990;
    localparam int TENTHS_MIN_X1 = -500;
    localparam int TENTHS_MAX_X1 = 2799;

    // Register index past the end of the register list.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [SAMPLE_BITS-1:0]   raw;
        bit                       known;
        t_light                   light;
        t_temp                    temp;
    } t_plan_row;

    typedef struct {
        t_light light;
        t_temp  temp;
    } t_reading;

    // DUT ports; every input starts at a known value.
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_stall;
    logic [SAMPLE_BITS-1:0]    i_raw_sample = '0;
    logic                      o_out_valid;
    logic                      i_out_stall  = 1'b0;
    logic [1:0]                o_light_state;
    logic signed [TEMP_BITS-1:0] o_temp_tenths;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data   = '0;

    // Alarm model: its own copy of the registers and of the light state.
    bit     cfg_ten         = 1'b1;
    t_temp  thr_low_enter   = RST_LOW_CRIT_ENTER;
    t_temp  thr_low_exit    = RST_LOW_CRIT_EXIT;
    t_temp  thr_warn_enter  = RST_WARN_ENTER;
    t_temp  thr_warn_exit   = RST_WARN_EXIT;
    t_temp  thr_high_enter  = RST_HIGH_CRIT_ENTER;
    t_temp  thr_high_exit   = RST_HIGH_CRIT_EXIT;
    t_light light_now       = LIGHT_GREEN;
    bit     seen_sample     = 1'b0;

    t_reading pending_readings[$];
    int       errors  = 0;
    int       sent    = 0;
    bit       steady  = 1'b0;     // no gaps and no stalls while set

    // Hand-typed expectation of the beat currently on the sample channel.
    bit     row_known   = 1'b0;
    t_light known_light = LIGHT_GREEN;
    t_temp  known_temp  = '0;

    temperature_alarm_hysteresis_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_sample        (i_raw_sample),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_light_state       (o_light_state),
        .o_temp_tenths       (o_temp_tenths),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Convert a converter reading to tenths: millivolts, minus offset, optional times ten.
    function automatic t_temp tenths_of(logic [SAMPLE_BITS-1:0] raw);
        int mv;
        int off;
        mv  = (int'(raw) * MV_FULL_SCALE) >> SAMPLE_BITS;
        off = mv - MV_OFFSET;
        if (cfg_ten) begin
            off = off * 10;
        end
        return t_temp'(off);
    endfunction

    function automatic bit is_critical(t_temp t);
        return (t < thr_low_enter) || (t >= thr_high_enter);
    endfunction

    // Hysteresis step. The first sample after reset takes the same path as green.
    function automatic t_light light_after(t_temp t, logic [1:0] code, bit fresh);
        t_light nxt;
        nxt = LIGHT_RED;
        if (fresh || code == LIGHT_GREEN) begin
            if (is_critical(t)) nxt = LIGHT_RED;
            else if (t >= thr_warn_enter) nxt = LIGHT_YELLOW;
            else nxt = LIGHT_GREEN;
        end else begin
            case (code)
                LIGHT_YELLOW: begin
                    if (is_critical(t)) nxt = LIGHT_RED;
                    else if (t < thr_warn_exit) nxt = LIGHT_GREEN;
                    else nxt = LIGHT_YELLOW;
                end
                LIGHT_RED: begin
                    // Stay red unless one of the exit windows is met.
                    if (t >= thr_low_exit && t < thr_warn_enter) nxt = LIGHT_GREEN;
                    else if (t >= thr_warn_enter && t < thr_high_exit) nxt = LIGHT_YELLOW;
                    else nxt = LIGHT_RED;
                end
                default: nxt = LIGHT_RED;   // unused code falls to red
            endcase
        end
        return nxt;
    endfunction

    function automatic void set_model_reg(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_SCALE_BY_TEN:    cfg_ten        = data[0];
            CFG_LOW_CRIT_ENTER:  thr_low_enter  = t_temp'(data);
            CFG_LOW_CRIT_EXIT:   thr_low_exit   = t_temp'(data);
            CFG_WARN_ENTER:      thr_warn_enter = t_temp'(data);
            CFG_WARN_EXIT:       thr_warn_exit  = t_temp'(data);
            CFG_HIGH_CRIT_ENTER: thr_high_enter = t_temp'(data);
            CFG_HIGH_CRIT_EXIT:  thr_high_exit  = t_temp'(data);
            default: ;           // index past the list: no effect
        endcase
    endfunction

    // Pick a reading that lands within a few codes of a given temperature.
    function automatic logic [SAMPLE_BITS-1:0] raw_near(int t, bit ten);
        int mv;
        int raw;
        mv  = (ten ? t / 10 : t) + MV_OFFSET;
        raw = (mv * (1 << SAMPLE_BITS) + MV_FULL_SCALE - 1) / MV_FULL_SCALE;
        raw = raw + int'($urandom_range(6, 0)) - 3;
        if (raw < 0) raw = 0;
        if (raw > RAW_MAX) raw = RAW_MAX;
        return raw[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_plan_row reg_row(logic [CFG_IDX_BITS-1:0] idx, int data);
        t_plan_row r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.data  = data[CFG_DATA_BITS-1:0];
        r.raw   = '0;
        r.known = 1'b0;
        r.light = LIGHT_GREEN;
        r.temp  = '0;
        return r;
    endfunction

    function automatic t_plan_row sample_row(int raw);
        t_plan_row r;
        r.kind  = ROW_SAMPLE;
        r.idx   = '0;
        r.data  = '0;
        r.raw   = raw[SAMPLE_BITS-1:0];
        r.known = 1'b0;
        r.light = LIGHT_GREEN;
        r.temp  = '0;
        return r;
    endfunction

    function automatic t_plan_row known_row(int raw, t_light light, int temp);
        t_plan_row r;
        r       = sample_row(raw);
        r.known = 1'b1;
        r.light = light;
        r.temp  = t_temp'(temp);
        return r;
    endfunction

    // Scoreboard: check the result beat first, then log the new sample beat and
    // any register write into the model. All three look at pre-edge values.
    always @(posedge i_clk) begin
        t_reading want;
        t_temp    t;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got light %0d temp %0d",
                             $time, o_light_state, o_temp_tenths);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_light_state !== want.light) begin
                        $display("%0t: light_state expected %0d, got %0d",
                                 $time, want.light, o_light_state);
                        errors++;
                    end
                    if (o_temp_tenths !== want.temp) begin
                        $display("%0t: temp_tenths expected %0d, got %0d",
                                 $time, want.temp, o_temp_tenths);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                t           = tenths_of(i_raw_sample);
                light_now   = light_after(t, light_now, !seen_sample);
                seen_sample = 1'b1;
                if (row_known) begin
                    want.light = known_light;
                    want.temp  = known_temp;
                end else begin
                    want.light = light_now;
                    want.temp  = t;
                end
                pending_readings.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                set_model_reg(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Receiver: stall about one time in five, never during a steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99, 0) < GAP_PERCENT);
    end

    // Drive one sample beat. Enter and leave at a falling edge; valid stays high
    // on return so that back-to-back beats never drop it.
    task automatic send_sample(logic [SAMPLE_BITS-1:0] raw, bit known, t_light light,
                               t_temp temp);
        i_cfg_valid <= 1'b0;
        while (!steady && $urandom_range(99, 0) < GAP_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        row_known    = known;
        known_light  = light;
        known_temp   = temp;
        i_raw_sample <= raw;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected reading is in, then let the pipe empty.
    task automatic settle();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One random phase: a fresh threshold setting, then a burst of samples.
    task automatic run_phase(int phase_no);
        int  thr[$];
        int  lo;
        int  hi;
        int  count;
        int  pick;
        int  walk;
        int  mode;
        bit  ten;
        logic [CFG_DATA_BITS-1:0] junk;
        logic [SAMPLE_BITS-1:0]   raw;

        settle();
        steady = (phase_no == 1) || ($urandom_range(4, 0) == 0);
        ten    = $urandom_range(1, 0);
        lo     = ten ? TENTHS_MIN : TENTHS_MIN_X1;
        hi     = ten ? TENTHS_MAX : TENTHS_MAX_X1;
        mode   = $urandom_range(3, 0);

        // Order: low enter, low exit, warn exit, warn enter, high exit, high enter.
        case (mode)
            0: thr = '{RST_LOW_CRIT_ENTER, RST_LOW_CRIT_EXIT, RST_WARN_EXIT,
                       RST_WARN_ENTER, RST_HIGH_CRIT_EXIT, RST_HIGH_CRIT_ENTER};
            1: begin
                // Consistent ladder inside the reachable span.
                repeat (6) thr.push_back(lo + int'($urandom_range(hi - lo, 0)));
                thr.sort();
            end
            2: begin
                // Any values in the full tenths span, in any order.
                repeat (6) thr.push_back(TENTHS_MIN +
                                         int'($urandom_range(TENTHS_MAX - TENTHS_MIN, 0)));
            end
            default: begin
                repeat (6) thr.push_back($urandom_range(1, 0) ? TENTHS_MAX : TENTHS_MIN);
            end
        endcase

        junk = $urandom;
        write_reg(CFG_SCALE_BY_TEN,    {junk[CFG_DATA_BITS-1:1], ten});
        write_reg(CFG_LOW_CRIT_ENTER,  16'(thr[0]));
        write_reg(CFG_LOW_CRIT_EXIT,   16'(thr[1]));
        write_reg(CFG_WARN_EXIT,       16'(thr[2]));
        write_reg(CFG_WARN_ENTER,      16'(thr[3]));
        write_reg(CFG_HIGH_CRIT_EXIT,  16'(thr[4]));
        write_reg(CFG_HIGH_CRIT_ENTER, 16'(thr[5]));
        if ($urandom_range(3, 0) == 0) begin
            write_reg(CFG_IDX_SPARE, 16'($urandom));
        end

        // Half hover around the thresholds; the rest follow a wandering walk or noise.
        count = $urandom_range(140, 60);
        walk  = $urandom_range(RAW_MAX, 0);
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                raw = raw_near(thr[$urandom_range(5, 0)], ten);
            end else if (pick < 80) begin
                walk = walk + int'($urandom_range(96, 0)) - 48;
                if (walk < 0) walk = 0;
                if (walk > RAW_MAX) walk = RAW_MAX;
                raw = walk[SAMPLE_BITS-1:0];
            end else begin
                raw = $urandom_range(RAW_MAX, 0);
            end
            send_sample(raw, 1'b0, LIGHT_GREEN, '0);
            sent++;
        end
    endtask

    initial begin
        t_plan_row plan[$];
        int        phase_no;

        // Directed table. Raw 646, 725 and 727 give 200, 840 and 850 tenths at
        // the reset scaling, right on the default warn band.
        plan.push_back(known_row(0, LIGHT_RED, -5000));        // first pick: below low enter
        plan.push_back(known_row(RAW_MAX, LIGHT_RED, 27990));  // full scale, red holds
        plan.push_back(sample_row(1000));                      // red, no exit window met
        plan.push_back(sample_row(727));                       // red to yellow
        plan.push_back(sample_row(646));                       // yellow to green
        plan.push_back(sample_row(727));                       // green to yellow at enter
        plan.push_back(sample_row(725));                       // yellow holds above exit
        plan.push_back(sample_row(RAW_MAX));                   // yellow to red
        plan.push_back(sample_row(646));                       // red to green
        plan.push_back(sample_row(0));                         // green to red
        plan.push_back(reg_row(CFG_SCALE_BY_TEN, 16'hFFFE));   // upper data bits ignored
        plan.push_back(known_row(0, LIGHT_RED, -500));
        plan.push_back(known_row(RAW_MAX, LIGHT_RED, 2799));
        plan.push_back(reg_row(CFG_IDX_SPARE, 16'h1234));      // index past the list
        plan.push_back(sample_row(646));
        plan.push_back(reg_row(CFG_SCALE_BY_TEN, 16'h0003));
        plan.push_back(reg_row(CFG_LOW_CRIT_ENTER, TENTHS_MIN));
        plan.push_back(reg_row(CFG_LOW_CRIT_EXIT, TENTHS_MIN));
        plan.push_back(reg_row(CFG_WARN_ENTER, TENTHS_MAX));
        plan.push_back(reg_row(CFG_WARN_EXIT, TENTHS_MAX));
        plan.push_back(reg_row(CFG_HIGH_CRIT_ENTER, TENTHS_MAX));
        plan.push_back(reg_row(CFG_HIGH_CRIT_EXIT, TENTHS_MAX));
        plan.push_back(sample_row(0));                         // red to green at the floor
        plan.push_back(sample_row(RAW_MAX));                   // at high enter: red
        plan.push_back(sample_row(1000));

        // Hold reset, then release on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_sample(plan[k].raw, plan[k].known, plan[k].light, plan[k].temp);
            end
        end

        phase_no = 0;
        while (sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        // Drop valid, wait out every reading, then let the pipe drain.
        steady = 1'b0;
        settle();

        if (errors == 0) begin
            $display("temperature_alarm_hysteresis_top verification clean");
        end else begin
            $display("temperature_alarm_hysteresis_top verification failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake or missing results end the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("temperature_alarm_hysteresis_top verification failed");
        $finish;
    end

endmodule
